// ===== src/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tei_pkg.sv =====
// shared types and constants of the tree ensemble scorer
// no dependencies
package tei_pkg;

	localparam int MAX_TREES_DEF      = 64;
	localparam int NODES_PER_TREE_DEF = 256;
	localparam int FEATURE_COUNT_DEF  = 64;
	localparam int MAX_WALK_DEF       = 16;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;
	localparam int PRED_W      = 48;

	localparam logic [30:0] DEFAULT_STEP_RST = 31'd6554;

	typedef enum logic [1:0] {
		REQ_WR_NODE = 2'd0,
		REQ_WR_STEP = 2'd1,
		REQ_WR_FEAT = 2'd2,
		REQ_EVAL    = 2'd3
	} req_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_INIT_PRED = 8'd0,
		REG_DEF_STEP  = 8'd1,
		REG_TREES     = 8'd2,
		REG_MISS_EN   = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		req_t        op;
		logic [5:0]  tree;
		logic [7:0]  node;
		logic [5:0]  feat;
		logic [31:0] data;
		logic [31:0] leaf;
		logic [7:0]  left;
		logic [7:0]  right;
		logic        is_leaf;
		logic        dleft;
		logic        missing;
	} cmd_t;

	typedef struct packed {
		logic        dleft;
		logic        is_leaf;
		logic [5:0]  feat;
		logic [7:0]  right;
		logic [7:0]  left;
		logic [31:0] leafv;
		logic [31:0] split;
	} node_t;

	typedef struct packed {
		logic [31:0] base_score;
		logic [30:0] def_step;
		logic [6:0]  trees;
		logic        miss_en;
	} cfg_t;

endpackage

// ===== src/tei_if.sv =====
// channel interfaces of the tree ensemble scorer: request, result, config write
// depends on tei_pkg
interface tei_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [5:0]  tree_index;
	logic [7:0]  node_index;
	logic [5:0]  feature_index;
	logic [31:0] data_value;
	logic [31:0] leaf_data;
	logic [7:0]  left_node;
	logic [7:0]  right_node;
	logic        node_is_leaf;
	logic        miss_left;
	logic        value_is_missing;

	modport source (output valid, req_type, tree_index, node_index, feature_index,
		data_value, leaf_data, left_node, right_node, node_is_leaf, miss_left,
		value_is_missing, input ready);
	modport sink (input valid, req_type, tree_index, node_index, feature_index,
		data_value, leaf_data, left_node, right_node, node_is_leaf, miss_left,
		value_is_missing, output ready);
endinterface

interface tei_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [tei_pkg::PRED_W-1:0] prediction;
	logic                              walk_overrun;

	modport source (output valid, prediction, walk_overrun, input ready);
	modport sink (input valid, prediction, walk_overrun, output ready);
endinterface

interface tei_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [tei_pkg::CFG_INDEX_W-1:0]    index;
	logic [tei_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/tei_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module tei_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/tei_front.sv =====
// request front end: takes request transfers, drops out-of-range writes, queues commands
// depends on tei_pkg and tei_if
module tei_front #(
	parameter int MAX_TREES      = tei_pkg::MAX_TREES_DEF,
	parameter int NODES_PER_TREE = tei_pkg::NODES_PER_TREE_DEF,
	parameter int FEATURE_COUNT  = tei_pkg::FEATURE_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	tei_req_if.sink         req,
	output tei_pkg::cmd_t   cmd,
	output logic            cmd_valid,
	input  logic            cmd_pop
);

	tei_pkg::cmd_t in_cmd;
	logic          keep;
	logic          push;

	tei_pkg::cmd_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	always_comb begin
		in_cmd.op      = tei_pkg::req_t'(req.req_type);
		in_cmd.tree    = req.tree_index;
		in_cmd.node    = req.node_index;
		in_cmd.feat    = req.feature_index;
		in_cmd.data    = req.data_value;
		in_cmd.leaf    = req.leaf_data;
		in_cmd.left    = req.left_node;
		in_cmd.right   = req.right_node;
		in_cmd.is_leaf = req.node_is_leaf;
		in_cmd.dleft   = req.miss_left;
		in_cmd.missing = req.value_is_missing;
	end

	// writes aimed outside the stores are accepted and forgotten
	always_comb begin
		case (in_cmd.op)
			tei_pkg::REQ_WR_NODE: keep = (32'(in_cmd.tree) < MAX_TREES) &&
				(32'(in_cmd.node) < NODES_PER_TREE);
			tei_pkg::REQ_WR_STEP: keep = 32'(in_cmd.tree) < MAX_TREES;
			tei_pkg::REQ_WR_FEAT: keep = 32'(in_cmd.feat) < FEATURE_COUNT;
			default:              keep = 1'b1;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready && keep;
	assign cmd       = ent_q[rd_ptr_q];
	assign cmd_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/tei_back.sv =====
// back end: carries out queued writes and walks the forest for an evaluation
// depends on tei_pkg, tei_if and tei_ram
module tei_back #(
	parameter int MAX_TREES      = tei_pkg::MAX_TREES_DEF,
	parameter int NODES_PER_TREE = tei_pkg::NODES_PER_TREE_DEF,
	parameter int FEATURE_COUNT  = tei_pkg::FEATURE_COUNT_DEF,
	parameter int MAX_WALK       = tei_pkg::MAX_WALK_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tei_pkg::cmd_t   cmd,
	input  logic            cmd_valid,
	output logic            cmd_pop,
	input  tei_pkg::cfg_t   cfg,
	tei_res_if.source       res
);

	localparam int TW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
	localparam int KW = $clog2(MAX_TREES + 1);
	localparam int NB = $clog2(NODES_PER_TREE);
	localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
	localparam int WW = (MAX_WALK > 1) ? $clog2(MAX_WALK) : 1;
	localparam int NODE_W = $bits(tei_pkg::node_t);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_TREE   = 7'b0000010,
		ST_RDNODE = 7'b0000100,
		ST_NODE   = 7'b0001000,
		ST_FEAT   = 7'b0010000,
		ST_MUL    = 7'b0100000,
		ST_ACC    = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [MAX_TREES-1:0]  present_q;
	logic [MAX_TREES-1:0]  loaded_q;
	logic [KW-1:0]         k_q;
	logic [NB-1:0]         node_q;
	logic [WW-1:0]         walk_q;
	logic                  over_q;
	logic [31:0]           leaf_q;
	logic signed [64:0]    prod_q;
	logic [47:0]           sum_q;
	logic                  res_valid_q;
	logic [47:0]           res_pred_q;
	logic                  res_over_q;

	logic [NODE_W-1:0]     node_rdata;
	logic [31:0]           step_rdata;
	logic [32:0]           feat_rdata;
	tei_pkg::node_t        nd;
	logic                  node_we;
	logic                  step_we;
	logic                  feat_we;
	logic [KW-1:0]         count;
	logic                  go_left;
	logic [7:0]            nxt;
	logic signed [32:0]    step;
	logic [49:0]           acc;
	logic [47:0]           acc_sat;
	logic                  done;
	logic                  res_load;

	assign nd       = tei_pkg::node_t'(node_rdata);
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign node_we  = cmd_pop && (cmd.op == tei_pkg::REQ_WR_NODE);
	assign step_we  = cmd_pop && (cmd.op == tei_pkg::REQ_WR_STEP);
	assign feat_we  = cmd_pop && (cmd.op == tei_pkg::REQ_WR_FEAT);
	assign count    = (32'(cfg.trees) > MAX_TREES) ? KW'(MAX_TREES) : KW'(cfg.trees);
	assign done     = (k_q == count);
	// the result register takes a new score once the previous one has gone
	assign res_load = (state_q == ST_TREE) && done && (!res_valid_q || res.ready);

	tei_ram #(.WIDTH(NODE_W), .DEPTH(MAX_TREES * (2 ** NB))) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr ({TW'(cmd.tree), NB'(cmd.node)}),
		.wdata ({cmd.dleft, cmd.is_leaf, cmd.feat, cmd.right, cmd.left, cmd.leaf, cmd.data}),
		.re    (state_q == ST_RDNODE),
		.raddr ({k_q[TW-1:0], node_q}),
		.rdata (node_rdata)
	);

	tei_ram #(.WIDTH(32), .DEPTH(MAX_TREES)) u_step_ram (
		.clk   (clk),
		.we    (step_we),
		.waddr (TW'(cmd.tree)),
		.wdata (cmd.data),
		.re    (state_q == ST_RDNODE),
		.raddr (k_q[TW-1:0]),
		.rdata (step_rdata)
	);

	tei_ram #(.WIDTH(33), .DEPTH(FEATURE_COUNT)) u_feat_ram (
		.clk   (clk),
		.we    (feat_we),
		.waddr (FW'(cmd.feat)),
		.wdata ({cmd.missing, cmd.data}),
		.re    (state_q == ST_NODE),
		.raddr (FW'(nd.feat)),
		.rdata (feat_rdata)
	);

	// branch decision; a missing value while disabled goes right
	always_comb begin
		if (32'(nd.feat) >= FEATURE_COUNT) begin
			go_left = nd.dleft;
		end else if (feat_rdata[32]) begin
			go_left = cfg.miss_en && nd.dleft;
		end else begin
			go_left = $signed(feat_rdata[31:0]) <= $signed(nd.split);
		end
		nxt = go_left ? nd.left : nd.right;
	end

	assign step = loaded_q[k_q[TW-1:0]] ? $signed({step_rdata[31], step_rdata}) :
		$signed({2'b00, cfg.def_step});

	// floor to q16.16 by dropping the low product bits, then saturate to 48 bits
	always_comb begin
		acc = {{2{sum_q[47]}}, sum_q} + {prod_q[64], prod_q[64:16]};
		if (acc[49:47] == 3'b000 || acc[49:47] == 3'b111) begin
			acc_sat = acc[47:0];
		end else if (acc[49]) begin
			acc_sat = {1'b1, 47'd0};
		end else begin
			acc_sat = {1'b0, {47{1'b1}}};
		end
	end

	assign res.valid        = res_valid_q;
	assign res.prediction   = res_pred_q;
	assign res.walk_overrun = res_over_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_NODE: begin
				leaf_q <= nd.leafv;
			end
			ST_FEAT: begin
				leaf_q <= 32'd0;
			end
			ST_MUL: begin
				prod_q <= step * $signed(leaf_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			present_q   <= '0;
			loaded_q    <= '0;
			k_q         <= '0;
			node_q      <= '0;
			walk_q      <= '0;
			over_q      <= 1'b0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
			res_pred_q  <= '0;
			res_over_q  <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && !res_load) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (node_we) begin
						present_q[TW'(cmd.tree)] <= 1'b1;
					end
					if (step_we) begin
						loaded_q[TW'(cmd.tree)] <= 1'b1;
					end
					if (cmd_pop && cmd.op == tei_pkg::REQ_EVAL) begin
						sum_q   <= {{16{cfg.base_score[31]}}, cfg.base_score};
						k_q     <= '0;
						over_q  <= 1'b0;
						state_q <= ST_TREE;
					end
				end
				ST_TREE: begin
					if (done) begin
						if (res_load) begin
							res_valid_q <= 1'b1;
							res_pred_q  <= sum_q;
							res_over_q  <= over_q;
							state_q     <= ST_IDLE;
						end
					end else if (!present_q[k_q[TW-1:0]]) begin
						k_q <= k_q + KW'(1);
					end else begin
						node_q  <= '0;
						walk_q  <= '0;
						state_q <= ST_RDNODE;
					end
				end
				ST_RDNODE: begin
					state_q <= ST_NODE;
				end
				ST_NODE: begin
					state_q <= nd.is_leaf ? ST_MUL : ST_FEAT;
				end
				ST_FEAT: begin
					if (32'(nxt) >= NODES_PER_TREE) begin
						state_q <= ST_MUL;
					end else if (walk_q == WW'(MAX_WALK - 1)) begin
						over_q  <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						walk_q  <= walk_q + WW'(1);
						node_q  <= NB'(nxt);
						state_q <= ST_RDNODE;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q   <= acc_sat;
					k_q     <= k_q + KW'(1);
					state_q <= ST_TREE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/tree_ensemble_inference.sv =====
// top level of the tree ensemble scorer: config registers, front end, back end
// depends on tei_pkg, tei_if, tei_front and tei_back
//
//   channel  modport  carries                               flow control
//   req      sink     node/step/feature writes, evaluate    valid/ready
//   res      source   prediction, walk_overrun              valid/ready
//   cfg      sink     register index, write data            valid/ready, always ready
//
// a write request is carried out by the back end as it pops it while idle; an evaluation skips
// each tree in use with no nodes and walks each tree in use that holds nodes from its root, as
// each inner node needs a node memory read then a feature memory read in series
// a two-entry queue parts the front from the back; req stalls only when it is full
// a pending result holds res and stalls the end of the next evaluation until taken
// arst_n clears control state and config registers; the memories are not cleared
module tree_ensemble_inference #(
	parameter int MAX_TREES      = tei_pkg::MAX_TREES_DEF,
	parameter int NODES_PER_TREE = tei_pkg::NODES_PER_TREE_DEF,
	parameter int FEATURE_COUNT  = tei_pkg::FEATURE_COUNT_DEF,
	parameter int MAX_WALK       = tei_pkg::MAX_WALK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tei_req_if.sink     req,
	tei_res_if.source   res,
	tei_cfg_if.sink     cfg
);

	tei_pkg::cfg_t cfg_q;
	tei_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_score <= '0;
			cfg_q.def_step   <= tei_pkg::DEFAULT_STEP_RST;
			cfg_q.trees      <= '0;
			cfg_q.miss_en    <= 1'b0;
		end else if (cfg.valid) begin
			case (tei_pkg::cfg_reg_t'(cfg.index))
				tei_pkg::REG_INIT_PRED: cfg_q.base_score <= cfg.data;
				tei_pkg::REG_DEF_STEP:  cfg_q.def_step   <= cfg.data[30:0];
				tei_pkg::REG_TREES:     cfg_q.trees      <= cfg.data[6:0];
				tei_pkg::REG_MISS_EN:   cfg_q.miss_en    <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	tei_front #(
		.MAX_TREES      (MAX_TREES),
		.NODES_PER_TREE (NODES_PER_TREE),
		.FEATURE_COUNT  (FEATURE_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	tei_back #(
		.MAX_TREES      (MAX_TREES),
		.NODES_PER_TREE (NODES_PER_TREE),
		.FEATURE_COUNT  (FEATURE_COUNT),
		.MAX_WALK       (MAX_WALK)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg_q),
		.res       (res)
	);

endmodule

// ===== src/tei_checker.sv =====
// port-level checks of the tree ensemble scorer, bound to the top level
// depends on assert_macros.svh and tree_ensemble_inference
`include "assert_macros.svh"

module tei_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [47:0] res_prediction,
	input logic        res_walk_overrun,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a stalled result keeps its payload
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_prediction) && $stable(res_walk_overrun), "result changed while stalled")

	// config writes never stall
	`ASSERT_IMPL(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "config port stalled")

	// an offered result carries no unknown bits
	`ASSERT_IMPL(a_res_known, clk, arst_n, res_valid, !$isunknown({res_prediction, res_walk_overrun}), "result payload unknown")

endmodule

bind tree_ensemble_inference tei_checker u_tei_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_prediction   (res.prediction),
	.res_walk_overrun (res.walk_overrun),
	.cfg_valid        (cfg.valid),
	.cfg_ready        (cfg.ready)
);

// ===== tb/tb_top.sv =====
// self-checking testbench of the tree ensemble scorer: a queue-fed request driver that
// updates a forest model, a result monitor, a config writer and a watchdog
// depends on tei_pkg, tei_if and tree_ensemble_inference
module tb_top;

	localparam int NT = tei_pkg::MAX_TREES_DEF;
	localparam int NN = tei_pkg::NODES_PER_TREE_DEF;
	localparam int NF = tei_pkg::FEATURE_COUNT_DEF;
	localparam int WALK_LIMIT = tei_pkg::MAX_WALK_DEF;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int HOLD_CYCLES = 600;
	localparam int CMD_W = $bits(tei_pkg::cmd_t);
	localparam logic [tei_pkg::CFG_INDEX_W-1:0] UNUSED_REG = 8'hFF;
	localparam longint SCORE_MAX = 64'sd140737488355327;
	localparam longint SCORE_MIN = -64'sd140737488355328;

	typedef struct {
		logic [tei_pkg::PRED_W-1:0] prediction;
		bit                         overrun;
	} score_t;

	logic clk;
	logic arst_n;

	tei_req_if req_ch();
	tei_res_if res_ch();
	tei_cfg_if cfg_ch();

	tree_ensemble_inference uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	// forest model, updated in transfer order
	tei_pkg::node_t forest[NT*NN];
	bit             tree_has_nodes[NT];
	logic [31:0]    tree_step[NT];
	bit             step_set[NT];
	logic [31:0]    feature_val[NF];
	bit             feature_miss[NF];
	tei_pkg::cfg_t  score_cfg;

	tei_pkg::cmd_t pending_reqs[$];
	score_t        pending_scores[$];

	// generator view: nodes 0..n-1 of a tree are written, children stay below n
	int gen_count[NT];

	int idle_pct;
	bit hold_req;
	bit hold_taken;
	int hold_left;
	int fails = 0;
	int n_reqs = 0;
	int n_scores = 0;
	int n_overruns = 0;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void score_sample(output score_t s);
		longint acc, leafv, stepv, term;
		int     cnt, node, k, i;
		bit     done, go_left;
		tei_pkg::node_t nd;
		s.overrun = 0;
		acc = longint'(signed'(score_cfg.base_score));
		cnt = (int'(score_cfg.trees) > NT) ? NT : int'(score_cfg.trees);
		for (k = 0; k < cnt; k++) begin
			if (!tree_has_nodes[k])
				continue;
			leafv = 0;
			node = 0;
			done = 0;
			for (i = 0; i < WALK_LIMIT && !done; i++) begin
				nd = forest[k*NN + node];
				if (nd.is_leaf) begin
					leafv = longint'(signed'(nd.leafv));
					done = 1;
				end else begin
					if (feature_miss[nd.feat])
						go_left = score_cfg.miss_en ? nd.dleft : 1'b0;
					else
						go_left = signed'(feature_val[nd.feat]) <= signed'(nd.split);
					node = go_left ? int'(nd.left) : int'(nd.right);
				end
			end
			if (!done)
				s.overrun = 1;
			stepv = step_set[k] ? longint'(signed'(tree_step[k]))
				: longint'({1'b0, score_cfg.def_step});
			// exact product, floor to q16.16
			term = (stepv * leafv) >>> 16;
			acc = acc + term;
			if (acc > SCORE_MAX)
				acc = SCORE_MAX;
			else if (acc < SCORE_MIN)
				acc = SCORE_MIN;
		end
		s.prediction = acc[tei_pkg::PRED_W-1:0];
	endfunction

	function automatic void apply_request(tei_pkg::cmd_t c);
		score_t s;
		case (c.op)
			tei_pkg::REQ_WR_NODE: begin
				forest[c.tree*NN + c.node] = '{dleft: c.dleft, is_leaf: c.is_leaf,
					feat: c.feat, right: c.right, left: c.left, leafv: c.leaf,
					split: c.data};
				tree_has_nodes[c.tree] = 1;
			end
			tei_pkg::REQ_WR_STEP: begin
				tree_step[c.tree] = c.data;
				step_set[c.tree] = 1;
			end
			tei_pkg::REQ_WR_FEAT: begin
				feature_val[c.feat] = c.data;
				feature_miss[c.feat] = c.missing;
			end
			default: begin
				score_sample(s);
				pending_scores = {pending_scores, s};
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h0;
			default: return $urandom();
		endcase
	endfunction

	function automatic tei_pkg::cmd_t filler(tei_pkg::req_t op);
		tei_pkg::cmd_t c;
		c = tei_pkg::cmd_t'(CMD_W'({$urandom(), $urandom(), $urandom(), $urandom()}));
		c.op = op;
		return c;
	endfunction

	function automatic tei_pkg::cmd_t gen_node_write();
		tei_pkg::cmd_t c;
		int   t, n;
		c = filler(tei_pkg::REQ_WR_NODE);
		t = $urandom_range(NT-2);
		n = gen_count[t];
		if (n >= 1 && $urandom_range(9) == 0) begin
			// slot far from anything reachable
			c.node = 8'($urandom_range(NN-1, 200));
		end else begin
			if (n < 15)
				c.node = 8'($urandom_range(n));
			else
				c.node = 8'($urandom_range(n-1));
			if (int'(c.node) == n)
				gen_count[t] = n + 1;
		end
		c.tree = 6'(t);
		c.data = pick_value();
		c.leaf = pick_value();
		c.is_leaf = ($urandom_range(9) < 4);
		if (!c.is_leaf) begin
			c.left = 8'($urandom_range(gen_count[t]-1));
			c.right = 8'($urandom_range(gen_count[t]-1));
		end
		return c;
	endfunction

	function automatic tei_pkg::cmd_t gen_random_req();
		tei_pkg::cmd_t c;
		int   r;
		r = $urandom_range(99);
		if (r < 40) begin
			c = gen_node_write();
		end else if (r < 50) begin
			c = filler(tei_pkg::REQ_WR_STEP);
			c.data = pick_value();
		end else if (r < 82) begin
			c = filler(tei_pkg::REQ_WR_FEAT);
			c.data = pick_value();
			c.missing = ($urandom_range(5) == 0);
		end else begin
			c = filler(tei_pkg::REQ_EVAL);
		end
		return c;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		tei_pkg::cmd_t c;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= '0;
			req_ch.tree_index <= '0;
			req_ch.node_index <= '0;
			req_ch.feature_index <= '0;
			req_ch.data_value <= '0;
			req_ch.leaf_data <= '0;
			req_ch.left_node <= '0;
			req_ch.right_node <= '0;
			req_ch.node_is_leaf <= 1'b0;
			req_ch.miss_left <= 1'b0;
			req_ch.value_is_missing <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				c = {tei_pkg::req_t'(req_ch.req_type), req_ch.tree_index,
					req_ch.node_index, req_ch.feature_index, req_ch.data_value,
					req_ch.leaf_data, req_ch.left_node, req_ch.right_node,
					req_ch.node_is_leaf, req_ch.miss_left, req_ch.value_is_missing};
				apply_request(c);
				n_reqs++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
					c = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= c.op;
					req_ch.tree_index <= c.tree;
					req_ch.node_index <= c.node;
					req_ch.feature_index <= c.feat;
					req_ch.data_value <= c.data;
					req_ch.leaf_data <= c.leaf;
					req_ch.left_node <= c.left;
					req_ch.right_node <= c.right;
					req_ch.node_is_leaf <= c.is_leaf;
					req_ch.miss_left <= c.dleft;
					req_ch.value_is_missing <= c.missing;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		score_t s;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_taken <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_scores.size() == 0) begin
					$error("result with no evaluation outstanding: prediction %0h",
						res_ch.prediction);
					fails++;
				end else begin
					s = pending_scores.pop_front();
					n_scores++;
					if (s.overrun)
						n_overruns++;
					if (res_ch.prediction !== s.prediction) begin
						$error("prediction: expected %0h, got %0h", s.prediction,
							res_ch.prediction);
						fails++;
					end
					if (res_ch.walk_overrun !== s.overrun) begin
						$error("walk_overrun: expected %0b, got %0b", s.overrun,
							res_ch.walk_overrun);
						fails++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_ch.ready <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				// long back-pressure so the request side fills up
				hold_taken <= 1;
				hold_left <= HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic cfg_write(logic [tei_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			tei_pkg::REG_INIT_PRED: score_cfg.base_score = val;
			tei_pkg::REG_DEF_STEP:  score_cfg.def_step = val[30:0];
			tei_pkg::REG_TREES:     score_cfg.trees = val[6:0];
			tei_pkg::REG_MISS_EN:   score_cfg.miss_en = val[0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || req_ch.valid || pending_scores.size() != 0)
			@(posedge clk);
		// writes may still be in the back end
		repeat (50) @(posedge clk);
	endtask

	function automatic tei_pkg::cmd_t node_req(int t, int n, int f, logic [31:0] split,
		logic [31:0] lv, int l, int r, bit lf, bit dl);
		tei_pkg::cmd_t c;
		c = filler(tei_pkg::REQ_WR_NODE);
		c.tree = 6'(t); c.node = 8'(n); c.feat = 6'(f); c.data = split; c.leaf = lv;
		c.left = 8'(l); c.right = 8'(r); c.is_leaf = lf; c.dleft = dl;
		return c;
	endfunction

	initial begin
		tei_pkg::cmd_t c;
		int   p, i;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		idle_pct = 19;
		hold_req = 0;
		score_cfg = '{base_score: 32'h0, def_step: tei_pkg::DEFAULT_STEP_RST,
			trees: 7'd0, miss_en: 1'b0};
		foreach (gen_count[t])
			gen_count[t] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// sample load, every slot, so no walk reads an unwritten feature
		for (i = 0; i < NF; i++) begin
			c = filler(tei_pkg::REQ_WR_FEAT);
			c.feat = 6'(i);
			c.data = (i == 0) ? 32'h7FFFFFFF : (i == 1) ? 32'h80000000 : pick_value();
			c.missing = (i == 2) || ($urandom_range(7) == 0);
			pending_reqs = {pending_reqs, c};
		end
		// tree 0: max feature equal to max split goes left onto a min leaf, unless feature 0 is marked missing
		pending_reqs = {pending_reqs, node_req(0, 0, 0, 32'h7FFFFFFF, 32'h0, 1, 2, 0, 0)};
		pending_reqs = {pending_reqs, node_req(0, 1, 5, 32'h0, 32'h80000000, 0, 0, 1, 0)};
		pending_reqs = {pending_reqs, node_req(0, 2, 5, 32'h0, 32'h7FFFFFFF, 0, 0, 1, 0)};
		gen_count[0] = 3;
		// tree 1: single leaf of -1, floor rounding of a tiny negative term
		pending_reqs = {pending_reqs,
			node_req(1, 0, 63, 32'h0, 32'hFFFFFFFF, 255, 255, 1, 1)};
		gen_count[1] = 1;
		// tree 63: missing feature, right child loops back to itself, left to slot 255
		pending_reqs = {pending_reqs,
			node_req(63, 255, 0, 32'h0, 32'h7FFFFFFF, 0, 0, 1, 1)};
		pending_reqs = {pending_reqs, node_req(63, 0, 2, 32'h0, 32'h0, 255, 0, 0, 1)};
		gen_count[63] = -1;
		c = filler(tei_pkg::REQ_WR_STEP); c.tree = 6'd0; c.data = 32'h80000000;
		pending_reqs = {pending_reqs, c};
		c = filler(tei_pkg::REQ_WR_STEP); c.tree = 6'd63; c.data = 32'h7FFFFFFF;
		pending_reqs = {pending_reqs, c};
		pending_reqs = {pending_reqs, filler(tei_pkg::REQ_EVAL)};
		drain();

		// all trees, tree 2 empty, missing goes right and loops
		cfg_write(tei_pkg::REG_TREES, 32'hFFFFFF7F);
		cfg_write(tei_pkg::REG_INIT_PRED, 32'h7FFFFFFF);
		cfg_write(tei_pkg::REG_DEF_STEP, 32'hFFFFFFFF);
		cfg_write(UNUSED_REG, $urandom());
		pending_reqs = {pending_reqs, filler(tei_pkg::REQ_EVAL)};
		drain();
		cfg_write(tei_pkg::REG_MISS_EN, 32'h1);
		cfg_write(tei_pkg::REG_INIT_PRED, 32'h80000000);
		cfg_write(tei_pkg::REG_DEF_STEP, 32'h0);
		cfg_write(tei_pkg::REG_TREES, 32'd64);
		pending_reqs = {pending_reqs, filler(tei_pkg::REQ_EVAL)};
		drain();
		cfg_write(tei_pkg::REG_TREES, 32'd2);
		pending_reqs = {pending_reqs, filler(tei_pkg::REQ_EVAL)};
		drain();

		for (p = 0; p < 8; p++) begin
			cfg_write(tei_pkg::REG_INIT_PRED, (p == 0) ? 32'h7FFFFFFF
				: (p == 1) ? 32'h80000000 : $urandom());
			cfg_write(tei_pkg::REG_DEF_STEP, (p == 2) ? 32'h0 : (p == 3) ? 32'h7FFFFFFF
				: $urandom());
			cfg_write(tei_pkg::REG_TREES, (p == 4) ? 32'd127 : (p == 5) ? 32'd64
				: (p == 6) ? 32'd1 : $urandom_range(64, 8));
			cfg_write(tei_pkg::REG_MISS_EN, 32'(p % 2));
			idle_pct = (p == 3) ? 0 : 19;
			hold_req = (p == 1);
			for (i = 0; i < 140; i++)
				pending_reqs = {pending_reqs, gen_random_req()};
			pending_reqs = {pending_reqs, filler(tei_pkg::REQ_EVAL)};
			drain();
		end

		$display("%0d requests sent, %0d scores checked, %0d with a walk overrun",
			n_reqs, n_scores, n_overruns);
		$display("eight random phases over extreme and random register settings");
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/tei_pkg.sv
src/tei_if.sv
src/tei_ram.sv
src/tei_front.sv
src/tei_back.sv
src/tree_ensemble_inference.sv
src/tei_checker.sv
tb/tb_top.sv
